>>> rtl/ncorr_pkg.sv
// Shared constants, types and state encoding for the normalised correlation block.
`default_nettype none

package ncorr_pkg;

    // Sample format and vector length limit.
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_LEN     = 1024;

    // Accumulator and result widths.
    localparam int PROD2_W = 2 * SAMPLE_BITS;
    localparam int DOT_W   = 42;
    localparam int EN_W    = 41;
    localparam int CNT_W   = 11;
    localparam int Q_W     = 16;

    // Normalisation datapath widths.
    localparam int MAG_W  = 41;
    localparam int PROD_W = 2 * EN_W;
    localparam int QUO_W  = 31;
    localparam int RAD_W  = QUO_W + 1;
    localparam int ROOT_W = Q_W;
    localparam int SQR_W  = ROOT_W + 4;

    // Iteration counts of the shared sequencer.
    localparam int MUL_STEPS  = EN_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int STEP_W     = 6;

    // Q1.15 limits.
    localparam int                      Q_ONE = 32768;
    localparam logic signed [Q_W-1:0]   Q_MAX = 16'sh7FFF;

    // Job queue between the accumulating front end and the normalising back end.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [EN_W-1:0]         ea;
        logic [EN_W-1:0]         eb;
        logic                    ovf;
        logic [CNT_W-1:0]        cnt;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DSET,
        ST_DIV,
        ST_SQRT,
        ST_WRITE
    } state_t;

endpackage

`default_nettype wire

>>> rtl/ncorr_front.sv
// Front end: accepts sample pairs and accumulates dot product, energies and pair count.
`default_nettype none

module ncorr_front (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic signed [ncorr_pkg::SAMPLE_BITS-1:0] sample_a,
    input  logic signed [ncorr_pkg::SAMPLE_BITS-1:0] sample_b,
    input  logic                                     last_pair,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  ncorr_pkg::q_status_t                     q_stat,
    output logic                                     push,
    output ncorr_pkg::job_t                          push_job
);
    import ncorr_pkg::*;

    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [EN_W-1:0]         ea_reg, ea_next;
    logic [EN_W-1:0]         eb_reg, eb_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    ovf_reg, ovf_next;

    logic signed [PROD2_W-1:0] p_ab, p_aa, p_bb;
    logic                      accept, take;
    job_t                      upd;

    assign p_ab = PROD2_W'(sample_a) * PROD2_W'(sample_b);
    assign p_aa = PROD2_W'(sample_a) * PROD2_W'(sample_a);
    assign p_bb = PROD2_W'(sample_b) * PROD2_W'(sample_b);

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign take     = cnt_reg < CNT_W'(MAX_LEN);

    // Accumulator contents once the current pair has been counted in.
    always_comb
    begin
        upd.dot = dot_reg;
        upd.ea  = ea_reg;
        upd.eb  = eb_reg;
        upd.cnt = cnt_reg;
        upd.ovf = ovf_reg;
        if (take)
        begin
            upd.dot = dot_reg + DOT_W'(p_ab);
            upd.ea  = ea_reg + EN_W'(unsigned'(p_aa));
            upd.eb  = eb_reg + EN_W'(unsigned'(p_bb));
            upd.cnt = cnt_reg + 1'b1;
        end
        else
        begin
            upd.ovf = 1'b1;
        end
    end

    assign push     = accept && last_pair;
    assign push_job = upd;

    always_comb
    begin
        dot_next = dot_reg;
        ea_next  = ea_reg;
        eb_next  = eb_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (accept)
        begin
            if (last_pair)
            begin
                dot_next = '0;
                ea_next  = '0;
                eb_next  = '0;
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                dot_next = upd.dot;
                ea_next  = upd.ea;
                eb_next  = upd.eb;
                cnt_next = upd.cnt;
                ovf_next = upd.ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            ea_reg  <= '0;
            eb_reg  <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            dot_reg <= dot_next;
            ea_reg  <= ea_next;
            eb_reg  <= eb_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

    a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_LEN))
        else $error("pair count beyond maximum length");

    a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("job pushed into a full queue");

    a_clear_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (cnt_reg == '0) && !ovf_reg && (ea_reg == '0))
        else $error("accumulators not cleared after the final pair");

endmodule

`default_nettype wire

>>> rtl/ncorr_queue.sv
// Short job queue decoupling the accumulating front end from the normalising back end.
`default_nettype none

module ncorr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ncorr_pkg::job_t      push_job,
    input  logic                 pop,
    output ncorr_pkg::job_t      head,
    output ncorr_pkg::q_status_t status
);
    import ncorr_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign status.full  = cnt_reg == QCNT_W'(QDEPTH);
    assign status.empty = cnt_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ncorr_back.sv
// Back end: sequential normalisation (shift-add products, restoring divide, digit square root).
`default_nettype none

module ncorr_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ncorr_pkg::job_t                     q_head,
    input  ncorr_pkg::q_status_t                q_stat,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ncorr_pkg::DOT_W-1:0]  raw_corr,
    output logic signed [ncorr_pkg::Q_W-1:0]    norm_corr_q15,
    output logic                                zero_energy,
    output logic                                length_overflow,
    output logic [ncorr_pkg::CNT_W-1:0]         pair_count
);
    import ncorr_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    job_t              job_reg, job_next;
    logic              job_zero_reg, job_zero_next;

    logic [PROD_W-1:0] mc_p_reg, mc_p_next, acc_p_reg, acc_p_next;
    logic [EN_W-1:0]   ml_p_reg, ml_p_next;
    logic [PROD_W-1:0] mc_d_reg, mc_d_next, acc_d_reg, acc_d_next;
    logic [MAG_W-1:0]  ml_d_reg, ml_d_next;

    logic [PROD_W-1:0] rem_reg, rem_next;
    logic              dbit_reg, dbit_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [SQR_W-1:0]  sq_rem_reg, sq_rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [DOT_W-1:0] out_raw_reg, out_raw_next;
    logic signed [Q_W-1:0]   out_norm_reg, out_norm_next;
    logic                    out_zero_reg, out_zero_next;
    logic                    out_ovf_reg, out_ovf_next;
    logic [CNT_W-1:0]        out_cnt_reg, out_cnt_next;

    logic signed [DOT_W-1:0] head_neg;
    logic [MAG_W-1:0]        head_mag;
    logic                    head_zero;
    logic [PROD_W-1:0]       div_sh, div_diff;
    logic                    div_ge;
    logic [SQR_W-1:0]        sq_cur, sq_trial;
    logic                    sq_ge;
    logic                    out_free;
    logic signed [Q_W-1:0]   norm_val;

    assign head_neg  = -q_head.dot;
    assign head_mag  = q_head.dot[DOT_W-1] ? head_neg[MAG_W-1:0] : q_head.dot[MAG_W-1:0];
    assign head_zero = (q_head.ea == '0) || (q_head.eb == '0);

    assign div_sh   = {rem_reg[PROD_W-2:0], dbit_reg};
    assign div_ge   = div_sh >= acc_p_reg;
    assign div_diff = div_sh - acc_p_reg;

    assign sq_cur   = {sq_rem_reg[SQR_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign sq_trial = SQR_W'({root_reg, 2'b01});
    assign sq_ge    = sq_cur >= sq_trial;

    assign out_free = !out_valid_reg || out_ready;

    // Zero energy gives 0; else sign and saturate the root, exactly +1.0 giving the largest positive code.
    always_comb
    begin
        if (job_zero_reg)
        begin
            norm_val = '0;
        end
        else if (job_reg.dot[DOT_W-1])
        begin
            norm_val = signed'(ROOT_W'(~root_reg + 1'b1));
        end
        else if (root_reg[ROOT_W-1])
        begin
            norm_val = Q_MAX;
        end
        else
        begin
            norm_val = signed'(root_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = head_zero ? ST_WRITE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    state_next = ST_DSET;
                end
            end
            ST_DSET:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop           = 1'b0;
        step_next     = step_reg;
        job_next      = job_reg;
        job_zero_next = job_zero_reg;
        mc_p_next     = mc_p_reg;
        ml_p_next     = ml_p_reg;
        acc_p_next    = acc_p_reg;
        mc_d_next     = mc_d_reg;
        ml_d_next     = ml_d_reg;
        acc_d_next    = acc_d_reg;
        rem_next      = rem_reg;
        dbit_next     = dbit_reg;
        quo_next      = quo_reg;
        rad_next      = rad_reg;
        sq_rem_next   = sq_rem_reg;
        root_next     = root_reg;
        out_raw_next  = out_raw_reg;
        out_norm_next = out_norm_reg;
        out_zero_next = out_zero_reg;
        out_ovf_next  = out_ovf_reg;
        out_cnt_next  = out_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop           = 1'b1;
                    job_next      = q_head;
                    job_zero_next = head_zero;
                    mc_p_next     = PROD_W'(q_head.ea);
                    ml_p_next     = q_head.eb;
                    acc_p_next    = '0;
                    mc_d_next     = PROD_W'(head_mag);
                    ml_d_next     = head_mag;
                    acc_d_next    = '0;
                    step_next     = '0;
                end
            end
            ST_MUL:
            begin
                acc_p_next = acc_p_reg + (ml_p_reg[0] ? mc_p_reg : '0);
                acc_d_next = acc_d_reg + (ml_d_reg[0] ? mc_d_reg : '0);
                mc_p_next  = mc_p_reg << 1;
                mc_d_next  = mc_d_reg << 1;
                ml_p_next  = ml_p_reg >> 1;
                ml_d_next  = ml_d_reg >> 1;
                step_next  = step_reg + 1'b1;
            end
            ST_DSET:
            begin
                // The dividend is the squared dot product shifted up by 30 bits; the
                // quotient fits 31 bits, so the top part starts below the divisor.
                rem_next  = acc_d_reg >> 1;
                dbit_next = acc_d_reg[0];
                quo_next  = '0;
                step_next = '0;
            end
            ST_DIV:
            begin
                rem_next  = div_ge ? div_diff : div_sh;
                quo_next  = {quo_reg[QUO_W-2:0], div_ge};
                dbit_next = 1'b0;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    rad_next    = {1'b0, quo_reg[QUO_W-2:0], div_ge};
                    sq_rem_next = '0;
                    root_next   = '0;
                    step_next   = '0;
                end
            end
            ST_SQRT:
            begin
                sq_rem_next = sq_ge ? (sq_cur - sq_trial) : sq_cur;
                root_next   = {root_reg[ROOT_W-2:0], sq_ge};
                rad_next    = rad_reg << 2;
                step_next   = step_reg + 1'b1;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_raw_next   = job_reg.dot;
                    out_norm_next  = norm_val;
                    out_zero_next  = job_zero_reg;
                    out_ovf_next   = job_reg.ovf;
                    out_cnt_next   = job_reg.cnt;
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        job_zero_reg <= job_zero_next;
        mc_p_reg     <= mc_p_next;
        ml_p_reg     <= ml_p_next;
        acc_p_reg    <= acc_p_next;
        mc_d_reg     <= mc_d_next;
        ml_d_reg     <= ml_d_next;
        acc_d_reg    <= acc_d_next;
        rem_reg      <= rem_next;
        dbit_reg     <= dbit_next;
        quo_reg      <= quo_next;
        rad_reg      <= rad_next;
        sq_rem_reg   <= sq_rem_next;
        root_reg     <= root_next;
        out_raw_reg  <= out_raw_next;
        out_norm_reg <= out_norm_next;
        out_zero_reg <= out_zero_next;
        out_ovf_reg  <= out_ovf_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign out_valid       = out_valid_reg;
    assign raw_corr        = out_raw_reg;
    assign norm_corr_q15   = out_norm_reg;
    assign zero_energy     = out_zero_reg;
    assign length_overflow = out_ovf_reg;
    assign pair_count      = out_cnt_reg;

    a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < acc_p_reg)
        else $error("division remainder not below divisor");

    a_root_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) && !job_zero_reg |-> root_reg <= ROOT_W'(Q_ONE))
        else $error("square root above unity");

    a_zero_norm : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_zero_reg |-> out_norm_reg == '0)
        else $error("zero energy result with non-zero normalised value");

endmodule

`default_nettype wire

>>> rtl/normalized_correlation.sv
// Top level of the streaming normalised cross-correlation block.
// Throughput: one sample pair per cycle while the job queue has room.
// Each vector pair then occupies the normalising back end for 41 shift-add steps, 31 divide
// steps and 16 square-root steps of one shared sequencer; zero energy skips all of them.
// Reset is asynchronous and active low; it clears accumulators, queue and sequencer.
`default_nettype none

module normalized_correlation (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic signed [ncorr_pkg::SAMPLE_BITS-1:0] sample_a,
    input  logic signed [ncorr_pkg::SAMPLE_BITS-1:0] sample_b,
    input  logic                                     last_pair,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [ncorr_pkg::DOT_W-1:0]       raw_corr,
    output logic signed [ncorr_pkg::Q_W-1:0]         norm_corr_q15,
    output logic                                     zero_energy,
    output logic                                     length_overflow,
    output logic [ncorr_pkg::CNT_W-1:0]              pair_count
);
    import ncorr_pkg::*;

    // The front end accumulates the dot product and both energies, one transaction per
    // cycle while the job queue has room. Pairs beyond the maximum length are dropped
    // and remembered as an overflow. On the final pair the completed sums are pushed as
    // one job into the queue and the accumulators start afresh in the same cycle.
    logic      push, pop;
    job_t      push_job, head_job;
    q_status_t q_stat;

    ncorr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_a  (sample_a),
        .sample_b  (sample_b),
        .last_pair (last_pair),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .q_stat    (q_stat),
        .push      (push),
        .push_job  (push_job)
    );

    // The queue lets the next vectors stream in while an earlier job is still being
    // normalised; the front end only stalls once the queue is full.
    ncorr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head_job),
        .status   (q_stat)
    );

    // The back end finds the largest q with q*q*Ea*Eb <= dot*dot*2^30: it forms both
    // products by shift-and-add, divides exactly by restoring division and takes the
    // integer square root digit by digit. The result waits in an output register, so
    // the back end may start on the next job while that transaction is still pending.
    ncorr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_head          (head_job),
        .q_stat          (q_stat),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .raw_corr        (raw_corr),
        .norm_corr_q15   (norm_corr_q15),
        .zero_energy     (zero_energy),
        .length_overflow (length_overflow),
        .pair_count      (pair_count)
    );

endmodule

`default_nettype wire
